[rtl/source_text_tokenizer_core_macros.svh]
// Assertion macros used by the tokenizer result queue (stt_res_fifo).
`ifndef SOURCE_TEXT_TOKENIZER_CORE_MACROS_SVH
`define SOURCE_TEXT_TOKENIZER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define STT_ASSERT_NOW(name, ck, rn, cond, prop) \
    name: assert property (@(posedge ck) disable iff (!rn) (cond) |-> (prop)) \
        else $error("Tokenizer assertion failed.");
`define STT_ASSERT_NEXT(name, ck, rn, cond, prop) \
    name: assert property (@(posedge ck) disable iff (!rn) (cond) |=> (prop)) \
        else $error("Tokenizer assertion failed.");
`else
`define STT_ASSERT_NOW(name, ck, rn, cond, prop)
`define STT_ASSERT_NEXT(name, ck, rn, cond, prop)
`endif
`endif

[rtl/stt_pkg.sv]
`timescale 1ns / 1ps

package stt_pkg;

    localparam int LINE_BITS = 16;
    localparam int RES_DEPTH = 4;
    localparam int RES_PTR_W = $clog2(RES_DEPTH);
    localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

    localparam logic [15:0] FIRST_LINE_RESET = 16'd1;

    localparam logic [7:0] CH_NUL        = 8'h00;
    localparam logic [7:0] CH_NL         = 8'h0A;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_DQUOTE     = 8'h22;
    localparam logic [7:0] CH_HASH       = 8'h23;
    localparam logic [7:0] CH_SQUOTE     = 8'h27;
    localparam logic [7:0] CH_ZERO       = 8'h30;
    localparam logic [7:0] CH_ONE        = 8'h31;
    localparam logic [7:0] CH_NINE       = 8'h39;
    localparam logic [7:0] CH_UP_A       = 8'h41;
    localparam logic [7:0] CH_UP_B       = 8'h42;
    localparam logic [7:0] CH_UP_F       = 8'h46;
    localparam logic [7:0] CH_UP_X       = 8'h58;
    localparam logic [7:0] CH_UP_Z       = 8'h5A;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_LO_A       = 8'h61;
    localparam logic [7:0] CH_LO_B       = 8'h62;
    localparam logic [7:0] CH_LO_F       = 8'h66;
    localparam logic [7:0] CH_LO_X       = 8'h78;
    localparam logic [7:0] CH_LO_Z       = 8'h7A;

    typedef enum logic [2:0] {
        KIND_END   = 3'd0,
        KIND_STR   = 3'd1,
        KIND_CHR   = 3'd2,
        KIND_HEX   = 3'd3,
        KIND_BIN   = 3'd4,
        KIND_DEC   = 3'd5,
        KIND_IDENT = 3'd6,
        KIND_OPER  = 3'd7
    } kind_t;

    typedef enum logic [13:0] {
        MODE_IDLE   = 14'b00000000000001,
        MODE_CSTART = 14'b00000000000010,
        MODE_CBLOCK = 14'b00000000000100,
        MODE_CLINE  = 14'b00000000001000,
        MODE_STR    = 14'b00000000010000,
        MODE_CHR    = 14'b00000000100000,
        MODE_ZERO   = 14'b00000001000000,
        MODE_HEXF   = 14'b00000010000000,
        MODE_BINF   = 14'b00000100000000,
        MODE_HEX    = 14'b00001000000000,
        MODE_BIN    = 14'b00010000000000,
        MODE_DEC    = 14'b00100000000000,
        MODE_IDENT  = 14'b01000000000000,
        MODE_OPER   = 14'b10000000000000
    } mode_t;

    typedef struct packed {
        mode_t                  mode;
        logic [7:0]             held_char;
        logic                   held_valid;
        logic                   held_first;
        kind_t                  held_kind;
        logic [LINE_BITS-1:0]   line;
    } scan_state_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  char_value;
        logic        has_char;
        logic        is_first;
        logic        is_last;
        logic [15:0] line_number;
    } token_t;

    typedef struct packed {
        logic [1:0] count;
        token_t     res0;
        token_t     res1;
    } push_t;

    function automatic logic [LINE_BITS-1:0] line_from_cfg(input logic [15:0] value);
        return LINE_BITS'(value);
    endfunction

    function automatic scan_state_t restart_state(input logic [15:0] value);
        scan_state_t s;
        s.mode       = MODE_IDLE;
        s.held_char  = 8'd0;
        s.held_valid = 1'b0;
        s.held_first = 1'b0;
        s.held_kind  = KIND_END;
        s.line       = line_from_cfg(value);
        return s;
    endfunction

endpackage

[rtl/stt_if.sv]
`timescale 1ns / 1ps

interface stt_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_input;

    modport source (output valid, output in_byte, output end_of_input, input ready);
    modport sink (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface stt_token_if;
    logic        valid;
    logic        ready;
    logic [2:0]  token_kind;
    logic [7:0]  char_value;
    logic        has_char;
    logic        is_first;
    logic        is_last;
    logic [15:0] line_number;

    modport source (output valid, output token_kind, output char_value, output has_char,
                    output is_first, output is_last, output line_number, input ready);
    modport sink (input valid, input token_kind, input char_value, input has_char,
                  input is_first, input is_last, input line_number, output ready);
endinterface

interface stt_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[rtl/stt_step.sv]
`timescale 1ns / 1ps

module stt_step
(
    input  stt_pkg::scan_state_t st,
    input  logic [7:0]           in_byte,
    input  logic                 end_of_input,
    input  logic [15:0]          first_line,
    output stt_pkg::scan_state_t st_next,
    output stt_pkg::push_t       results
);

    function automatic logic is_dig(input logic [7:0] b);
        return (b >= stt_pkg::CH_ZERO) && (b <= stt_pkg::CH_NINE);
    endfunction

    function automatic logic is_alp(input logic [7:0] b);
        return ((b >= stt_pkg::CH_LO_A) && (b <= stt_pkg::CH_LO_Z))
            || ((b >= stt_pkg::CH_UP_A) && (b <= stt_pkg::CH_UP_Z));
    endfunction

    function automatic logic is_hex(input logic [7:0] b);
        return is_dig(b) || ((b >= stt_pkg::CH_LO_A) && (b <= stt_pkg::CH_LO_F))
            || ((b >= stt_pkg::CH_UP_A) && (b <= stt_pkg::CH_UP_F));
    endfunction

    function automatic stt_pkg::token_t mk_tok(input stt_pkg::kind_t kind,
                                              input logic [7:0] ch, input logic has,
                                              input logic first, input logic last,
                                              input logic [15:0] line);
        stt_pkg::token_t t;
        t.kind        = kind;
        t.char_value  = has ? ch : 8'd0;
        t.has_char    = has;
        t.is_first    = first;
        t.is_last     = last;
        t.line_number = line;
        return t;
    endfunction

    stt_pkg::mode_t id_mode;
    logic           id_hold;
    stt_pkg::kind_t id_kind;
    logic           id_inc;

    logic           fin;
    stt_pkg::kind_t fin_kind;
    logic           rescan;
    logic           hold_en;
    stt_pkg::kind_t hold_kind;
    logic           drop;
    logic           inc;
    stt_pkg::mode_t mode_after;

    logic           eoi_fin;
    stt_pkg::kind_t eoi_kind;
    logic [15:0]    line_out;

    assign line_out = 16'(st.line);

    // Decode of a byte seen between tokens.
    always_comb
    begin
        id_mode = stt_pkg::MODE_IDLE;
        id_hold = 1'b0;
        id_kind = stt_pkg::KIND_OPER;
        id_inc  = 1'b0;
        if (in_byte <= stt_pkg::CH_SPACE)
        begin
            id_inc = (in_byte == stt_pkg::CH_NL);
        end
        else if (in_byte == stt_pkg::CH_HASH)
        begin
            id_mode = stt_pkg::MODE_CSTART;
        end
        else if (in_byte == stt_pkg::CH_DQUOTE)
        begin
            id_mode = stt_pkg::MODE_STR;
        end
        else if (in_byte == stt_pkg::CH_SQUOTE)
        begin
            id_mode = stt_pkg::MODE_CHR;
        end
        else if (in_byte == stt_pkg::CH_ZERO)
        begin
            id_mode = stt_pkg::MODE_ZERO;
            id_hold = 1'b1;
            id_kind = stt_pkg::KIND_DEC;
        end
        else if (is_dig(in_byte))
        begin
            id_mode = stt_pkg::MODE_DEC;
            id_hold = 1'b1;
            id_kind = stt_pkg::KIND_DEC;
        end
        else if (is_alp(in_byte))
        begin
            id_mode = stt_pkg::MODE_IDENT;
            id_hold = 1'b1;
            id_kind = stt_pkg::KIND_IDENT;
        end
        else
        begin
            id_mode = stt_pkg::MODE_OPER;
            id_hold = 1'b1;
            id_kind = stt_pkg::KIND_OPER;
        end
    end

    // Action chosen by the current mode for an ordinary byte.
    always_comb
    begin
        fin        = 1'b0;
        fin_kind   = stt_pkg::KIND_END;
        rescan     = 1'b0;
        hold_en    = 1'b0;
        hold_kind  = stt_pkg::KIND_OPER;
        drop       = 1'b0;
        inc        = 1'b0;
        mode_after = st.mode;
        case (st.mode)
            stt_pkg::MODE_CSTART:
            begin
                if (in_byte == stt_pkg::CH_HASH)
                begin
                    mode_after = stt_pkg::MODE_CLINE;
                end
                else
                begin
                    inc        = (in_byte == stt_pkg::CH_NL);
                    mode_after = stt_pkg::MODE_CBLOCK;
                end
            end
            stt_pkg::MODE_CBLOCK:
            begin
                if ((in_byte == stt_pkg::CH_HASH) || (in_byte == stt_pkg::CH_NUL))
                begin
                    mode_after = stt_pkg::MODE_IDLE;
                end
                else
                begin
                    inc = (in_byte == stt_pkg::CH_NL);
                end
            end
            stt_pkg::MODE_CLINE:
            begin
                if (in_byte == stt_pkg::CH_NL)
                begin
                    inc        = 1'b1;
                    mode_after = stt_pkg::MODE_IDLE;
                end
                else if (in_byte == stt_pkg::CH_NUL)
                begin
                    mode_after = stt_pkg::MODE_IDLE;
                end
            end
            stt_pkg::MODE_STR:
            begin
                if (in_byte == stt_pkg::CH_DQUOTE)
                begin
                    fin        = 1'b1;
                    fin_kind   = stt_pkg::KIND_STR;
                    mode_after = stt_pkg::MODE_IDLE;
                end
                else
                begin
                    hold_en   = 1'b1;
                    hold_kind = stt_pkg::KIND_STR;
                end
            end
            stt_pkg::MODE_CHR:
            begin
                if (in_byte == stt_pkg::CH_SQUOTE)
                begin
                    fin        = 1'b1;
                    fin_kind   = stt_pkg::KIND_CHR;
                    mode_after = stt_pkg::MODE_IDLE;
                end
                else
                begin
                    hold_en   = 1'b1;
                    hold_kind = stt_pkg::KIND_CHR;
                end
            end
            stt_pkg::MODE_ZERO:
            begin
                if ((in_byte == stt_pkg::CH_LO_X) || (in_byte == stt_pkg::CH_UP_X))
                begin
                    drop       = 1'b1;
                    mode_after = stt_pkg::MODE_HEXF;
                end
                else if ((in_byte == stt_pkg::CH_LO_B) || (in_byte == stt_pkg::CH_UP_B))
                begin
                    drop       = 1'b1;
                    mode_after = stt_pkg::MODE_BINF;
                end
                else if (is_dig(in_byte))
                begin
                    hold_en    = 1'b1;
                    hold_kind  = stt_pkg::KIND_DEC;
                    mode_after = stt_pkg::MODE_DEC;
                end
                else
                begin
                    fin      = 1'b1;
                    fin_kind = stt_pkg::KIND_DEC;
                    rescan   = 1'b1;
                end
            end
            stt_pkg::MODE_HEXF:
            begin
                hold_en    = 1'b1;
                hold_kind  = stt_pkg::KIND_HEX;
                mode_after = stt_pkg::MODE_HEX;
            end
            stt_pkg::MODE_BINF:
            begin
                hold_en    = 1'b1;
                hold_kind  = stt_pkg::KIND_BIN;
                mode_after = stt_pkg::MODE_BIN;
            end
            stt_pkg::MODE_HEX:
            begin
                hold_kind = stt_pkg::KIND_HEX;
                fin_kind  = stt_pkg::KIND_HEX;
                hold_en   = is_hex(in_byte);
                fin       = !is_hex(in_byte);
                rescan    = !is_hex(in_byte);
            end
            stt_pkg::MODE_BIN:
            begin
                hold_kind = stt_pkg::KIND_BIN;
                fin_kind  = stt_pkg::KIND_BIN;
                hold_en   = (in_byte == stt_pkg::CH_ZERO) || (in_byte == stt_pkg::CH_ONE);
                fin       = !hold_en;
                rescan    = !hold_en;
            end
            stt_pkg::MODE_DEC:
            begin
                hold_kind = stt_pkg::KIND_DEC;
                fin_kind  = stt_pkg::KIND_DEC;
                hold_en   = is_dig(in_byte);
                fin       = !is_dig(in_byte);
                rescan    = !is_dig(in_byte);
            end
            stt_pkg::MODE_IDENT:
            begin
                hold_kind = stt_pkg::KIND_IDENT;
                fin_kind  = stt_pkg::KIND_IDENT;
                hold_en   = is_alp(in_byte) || is_dig(in_byte)
                         || (in_byte == stt_pkg::CH_UNDERSCORE);
                fin       = !hold_en;
                rescan    = !hold_en;
            end
            stt_pkg::MODE_OPER:
            begin
                fin      = 1'b1;
                fin_kind = stt_pkg::KIND_OPER;
                rescan   = 1'b1;
            end
            default:
            begin
                rescan = 1'b1;
            end
        endcase
        if (rescan)
        begin
            mode_after = id_mode;
            hold_en    = id_hold;
            hold_kind  = id_kind;
            inc        = id_inc;
        end
    end

    // Kind of the token that an end of input completes, if any.
    always_comb
    begin
        eoi_fin  = 1'b1;
        eoi_kind = stt_pkg::KIND_END;
        case (st.mode)
            stt_pkg::MODE_STR:   eoi_kind = stt_pkg::KIND_STR;
            stt_pkg::MODE_CHR:   eoi_kind = stt_pkg::KIND_CHR;
            stt_pkg::MODE_ZERO:  eoi_kind = stt_pkg::KIND_DEC;
            stt_pkg::MODE_HEXF:  eoi_kind = stt_pkg::KIND_HEX;
            stt_pkg::MODE_HEX:   eoi_kind = stt_pkg::KIND_HEX;
            stt_pkg::MODE_BINF:  eoi_kind = stt_pkg::KIND_BIN;
            stt_pkg::MODE_BIN:   eoi_kind = stt_pkg::KIND_BIN;
            stt_pkg::MODE_DEC:   eoi_kind = stt_pkg::KIND_DEC;
            stt_pkg::MODE_IDENT: eoi_kind = stt_pkg::KIND_IDENT;
            stt_pkg::MODE_OPER:  eoi_kind = stt_pkg::KIND_OPER;
            default:             eoi_fin  = 1'b0;
        endcase
    end

    // Assembly of the results and the next state.
    always_comb
    begin
        stt_pkg::scan_state_t nx;
        stt_pkg::token_t      r0;
        stt_pkg::token_t      r1;
        logic [1:0]           cnt;
        nx  = st;
        r0  = '0;
        r1  = '0;
        cnt = 2'd0;
        if (end_of_input)
        begin
            if (eoi_fin)
            begin
                r0 = st.held_valid
                   ? mk_tok(st.held_kind, st.held_char, 1'b1, st.held_first, 1'b1, line_out)
                   : mk_tok(eoi_kind, 8'd0, 1'b0, 1'b1, 1'b1, line_out);
                r1  = mk_tok(stt_pkg::KIND_END, 8'd0, 1'b0, 1'b1, 1'b1, line_out);
                cnt = 2'd2;
            end
            else
            begin
                r0  = mk_tok(stt_pkg::KIND_END, 8'd0, 1'b0, 1'b1, 1'b1, line_out);
                cnt = 2'd1;
            end
            nx = stt_pkg::restart_state(first_line);
        end
        else
        begin
            if (fin)
            begin
                r0 = st.held_valid
                   ? mk_tok(st.held_kind, st.held_char, 1'b1, st.held_first, 1'b1, line_out)
                   : mk_tok(fin_kind, 8'd0, 1'b0, 1'b1, 1'b1, line_out);
                cnt           = 2'd1;
                nx.held_valid = 1'b0;
                nx.held_first = 1'b0;
                nx.held_char  = 8'd0;
                nx.held_kind  = stt_pkg::KIND_END;
            end
            if (drop)
            begin
                nx.held_valid = 1'b0;
            end
            // A finish always empties the holding slot, so a hold that emits
            // is always the first result of the step.
            if (hold_en)
            begin
                if (nx.held_valid)
                begin
                    r0  = mk_tok(nx.held_kind, nx.held_char, 1'b1, nx.held_first, 1'b0,
                                 line_out);
                    cnt = 2'd1;
                end
                nx.held_first = !nx.held_valid;
                nx.held_char  = in_byte;
                nx.held_kind  = hold_kind;
                nx.held_valid = 1'b1;
            end
            nx.mode = mode_after;
            if (inc && (st.line != '1))
            begin
                nx.line = st.line + 1'b1;
            end
        end
        st_next       = nx;
        results.count = cnt;
        results.res0  = r0;
        results.res1  = r1;
    end

endmodule

[rtl/stt_res_fifo.sv]
`timescale 1ns / 1ps
`include "source_text_tokenizer_core_macros.svh"

module stt_res_fifo
(
    input  logic               clk,
    input  logic               rst_n,
    input  stt_pkg::push_t     push,
    output logic               room,
    stt_token_if.source        tokens
);

    stt_pkg::token_t mem [stt_pkg::RES_DEPTH];

    logic [stt_pkg::RES_PTR_W-1:0] wr_ptr_reg;
    logic [stt_pkg::RES_PTR_W-1:0] wr_ptr_next;
    logic [stt_pkg::RES_PTR_W-1:0] wr_ptr_inc;
    logic [stt_pkg::RES_PTR_W-1:0] rd_ptr_reg;
    logic [stt_pkg::RES_PTR_W-1:0] rd_ptr_next;
    logic [stt_pkg::RES_CNT_W-1:0] cnt_reg;
    logic [stt_pkg::RES_CNT_W-1:0] cnt_next;
    logic                          pop;
    stt_pkg::token_t               head;

    assign pop        = tokens.valid && tokens.ready;
    assign wr_ptr_inc = wr_ptr_reg + 1'b1;
    assign room       = (32'(cnt_reg) <= (stt_pkg::RES_DEPTH - 2));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + stt_pkg::RES_PTR_W'(push.count);
        rd_ptr_next = rd_ptr_reg + stt_pkg::RES_PTR_W'(pop);
        cnt_next    = cnt_reg + stt_pkg::RES_CNT_W'(push.count)
                    - stt_pkg::RES_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem[wr_ptr_reg] <= push.res0;
        end
        if (push.count == 2'd2)
        begin
            mem[wr_ptr_inc] <= push.res1;
        end
    end

    assign head               = mem[rd_ptr_reg];
    assign tokens.valid       = (cnt_reg != '0);
    assign tokens.token_kind  = head.kind;
    assign tokens.char_value  = head.char_value;
    assign tokens.has_char    = head.has_char;
    assign tokens.is_first    = head.is_first;
    assign tokens.is_last     = head.is_last;
    assign tokens.line_number = head.line_number;

    `STT_ASSERT_NOW(a_cnt_bound, clk, rst_n, 1'b1, 32'(cnt_reg) <= stt_pkg::RES_DEPTH)
    `STT_ASSERT_NOW(a_push_room, clk, rst_n, push.count != 2'd0, room)
    `STT_ASSERT_NEXT(a_pop_only, clk, rst_n, pop && (push.count == 2'd0), 32'(cnt_reg) == 32'($past(cnt_reg)) - 1)

endmodule

[rtl/source_text_tokenizer_core.sv]
`timescale 1ns / 1ps
// A byte is registered on acceptance. The scan step works on the registered byte, and its
// results are written into the result queue when the step proceeds, which waits until the
// queue has room for two results; the queue offers its head from its registered entries.
// Throughput: one byte per cycle while the result queue has room; a byte that gives two
// results needs two output transactions. The rate is set by the combinational scan step
// and the four-entry result queue. Reset is asynchronous and active low: the scanner goes
// idle, first_line returns to 1 and the line counter loads 1. Input is accepted out of reset.

module source_text_tokenizer_core
(
    input logic          clk,
    input logic          rst_n,
    stt_byte_if.sink     bytes,
    stt_cfg_if.sink      cfg,
    stt_token_if.source  tokens
);

    logic                 in_valid_reg;
    logic [7:0]           byte_reg;
    logic                 eoi_reg;
    logic [15:0]          first_line_reg;
    stt_pkg::scan_state_t st_reg;
    stt_pkg::scan_state_t st_next;
    stt_pkg::push_t       step_res;
    stt_pkg::push_t       push;
    logic                 room;
    logic                 proceed;
    logic                 take;

    assign proceed     = in_valid_reg && room;
    assign bytes.ready = !in_valid_reg || proceed;
    assign take        = bytes.valid && bytes.ready;
    assign cfg.ready   = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            first_line_reg <= stt_pkg::FIRST_LINE_RESET;
            st_reg         <= stt_pkg::restart_state(stt_pkg::FIRST_LINE_RESET);
        end
        else
        begin
            if (take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (proceed)
            begin
                in_valid_reg <= 1'b0;
            end
            if (cfg.valid)
            begin
                first_line_reg <= cfg.data;
            end
            if (proceed)
            begin
                st_reg <= st_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            byte_reg <= bytes.in_byte;
            eoi_reg  <= bytes.end_of_input;
        end
    end

    stt_step u_step
    (
        .st           (st_reg),
        .in_byte      (byte_reg),
        .end_of_input (eoi_reg),
        .first_line   (first_line_reg),
        .st_next      (st_next),
        .results      (step_res)
    );

    always_comb
    begin
        push       = step_res;
        push.count = proceed ? step_res.count : 2'd0;
    end

    stt_res_fifo u_res_fifo
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .room   (room),
        .tokens (tokens)
    );

endmodule
